// ----- src/wlc_pkg.sv -----
// ----------------------------------------------------------------------------
// wlc_pkg: shared types for the weighted least-connection picker
// Slot record layout, sequencer states and multiply unit control.
// ----------------------------------------------------------------------------
package wlc_pkg;

    localparam int ADDR_W  = 32;
    localparam int PRIO_W  = 16;
    localparam int WGT_W   = 16;
    localparam int CNT_W   = 32;
    localparam int IDX_W   = 4;
    localparam int PROD_W  = CNT_W + WGT_W;

    localparam logic OP_WRITE    = 1'b0;
    localparam logic OP_SCHEDULE = 1'b1;

    // one table slot as held in memory (the valid mark lives in flops)
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [PRIO_W-1:0] prio;
        logic [WGT_W-1:0]  weight;
        logic [CNT_W-1:0]  count;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MUL_A,
        S_MUL_B,
        S_CMP,
        S_FETCH,
        S_UPDATE,
        S_RESP
    } t_state;

    // control of the shared multiply unit
    typedef struct packed {
        logic load_a;   // candidate count * pick weight
        logic load_b;   // pick count * candidate weight
    } t_mul_ctrl;

endpackage

// ----- src/weighted_least_conn_picker.sv -----
// ----------------------------------------------------------------------------
// weighted_least_conn_picker: server table with weighted least-conn pick
// Holds MAX_SERVERS slots; a write item loads one slot, a schedule item
// walks the slots and picks the lowest count/weight within the first tier.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  request   in         i_valid/o_ready    i_operation, i_entry_*, i_skip_addr
//  result    out        o_valid/i_ready    o_found, o_chosen_index, o_chosen_addr
//
//  Write item: accepted, then the result is shown.
//  Schedule item: the accept, a walk through the slots in S_EVAL, for each slot
//  cross-multiplied against the pick on the shared multiplier the states S_MUL_A,
//  S_MUL_B and S_CMP (then S_FETCH unless it is the last slot), S_UPDATE for the
//  count write-back when a server is picked, then the result in S_RESP.
//  One item at a time: o_ready is low from acceptance until the result is taken.
//  Reset clears the valid marks; the slot memory is not cleared.
// ----------------------------------------------------------------------------
module weighted_least_conn_picker #(
    parameter int MAX_SERVERS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_operation,
    input  logic [wlc_pkg::IDX_W-1:0]      i_entry_index,
    input  logic                           i_entry_valid,
    input  logic [wlc_pkg::ADDR_W-1:0]     i_entry_addr,
    input  logic [wlc_pkg::PRIO_W-1:0]     i_entry_priority,
    input  logic [wlc_pkg::WGT_W-1:0]      i_entry_weight,
    input  logic [wlc_pkg::CNT_W-1:0]      i_entry_count,
    input  logic [wlc_pkg::ADDR_W-1:0]     i_skip_addr,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_found,
    output logic [wlc_pkg::IDX_W-1:0]      o_chosen_index,
    output logic [wlc_pkg::ADDR_W-1:0]     o_chosen_addr
);

    localparam int IW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_SERVERS - 1);

    wlc_pkg::t_state r_state;
    wlc_pkg::t_state n_state;

    logic [MAX_SERVERS-1:0]        r_valid;
    logic [MAX_SERVERS-1:0]        n_valid;
    logic [IW-1:0]                 r_idx;
    logic [IW-1:0]                 n_idx;
    logic [wlc_pkg::ADDR_W-1:0]    r_skip;
    logic [wlc_pkg::ADDR_W-1:0]    n_skip;
    logic [wlc_pkg::PRIO_W-1:0]    r_tier;
    logic [wlc_pkg::PRIO_W-1:0]    n_tier;
    logic                          r_picked;
    logic                          n_picked;
    logic [IW-1:0]                 r_pick_idx;
    logic [IW-1:0]                 n_pick_idx;
    wlc_pkg::t_entry               r_pick;
    wlc_pkg::t_entry               n_pick;
    wlc_pkg::t_entry               r_cand;
    wlc_pkg::t_entry               n_cand;
    logic                          r_found;
    logic                          n_found;
    logic [wlc_pkg::IDX_W-1:0]     r_chosen_idx;
    logic [wlc_pkg::IDX_W-1:0]     n_chosen_idx;
    logic [wlc_pkg::ADDR_W-1:0]    r_chosen_addr;
    logic [wlc_pkg::ADDR_W-1:0]    n_chosen_addr;

    logic                          w_accept;
    logic                          w_wr_item;
    logic                          w_wr_in_range;
    logic                          w_ram_we;
    logic [IW-1:0]                 w_ram_waddr;
    wlc_pkg::t_entry               w_ram_wdata;
    logic [IW-1:0]                 w_ram_raddr;
    logic [$bits(wlc_pkg::t_entry)-1:0] w_ram_rdata;
    wlc_pkg::t_entry               w_rd;
    wlc_pkg::t_mul_ctrl            w_mul_ctrl;
    logic                          w_less;

    logic                          w_slot_on;
    logic [wlc_pkg::PRIO_W-1:0]    w_tier_t;
    logic                          w_elig;
    logic                          w_zero;
    logic                          w_first;
    logic                          w_cmp;
    logic                          w_last;
    logic [wlc_pkg::CNT_W-1:0]     w_cnt_inc;

    assign w_accept      = i_valid && o_ready;
    assign w_wr_item     = w_accept && (i_operation == wlc_pkg::OP_WRITE);
    assign w_wr_in_range = 32'(i_entry_index) < MAX_SERVERS;
    assign w_rd          = w_ram_rdata;

    // slot decision for the entry on the memory output
    assign w_slot_on = r_valid[r_idx] && (w_rd.addr != r_skip);
    assign w_tier_t  = (r_tier == '0) ? w_rd.prio : r_tier;
    assign w_elig    = w_slot_on && (w_rd.weight != '0)
                       && (!r_picked || (w_rd.prio == w_tier_t));
    assign w_zero    = w_elig && (w_rd.count == '0);
    assign w_first   = w_elig && !r_picked && (w_rd.count != '0);
    assign w_cmp     = w_elig && r_picked && (w_rd.count != '0);
    assign w_last    = r_idx == LAST_IDX;
    assign w_cnt_inc = (r_pick.count == '1) ? r_pick.count
                                            : r_pick.count + wlc_pkg::CNT_W'(1);

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wlc_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_operation == wlc_pkg::OP_WRITE) ? wlc_pkg::S_RESP
                                                                 : wlc_pkg::S_EVAL;
                end
            end
            wlc_pkg::S_EVAL: begin
                if (w_zero) begin
                    n_state = wlc_pkg::S_UPDATE;
                end else if (w_cmp) begin
                    n_state = wlc_pkg::S_MUL_A;
                end else if (w_last) begin
                    n_state = (r_picked || w_first) ? wlc_pkg::S_UPDATE
                                                    : wlc_pkg::S_RESP;
                end
            end
            wlc_pkg::S_MUL_A:  n_state = wlc_pkg::S_MUL_B;
            wlc_pkg::S_MUL_B:  n_state = wlc_pkg::S_CMP;
            wlc_pkg::S_CMP:    n_state = w_last ? wlc_pkg::S_UPDATE : wlc_pkg::S_FETCH;
            wlc_pkg::S_FETCH:  n_state = wlc_pkg::S_EVAL;
            wlc_pkg::S_UPDATE: n_state = wlc_pkg::S_RESP;
            wlc_pkg::S_RESP: begin
                if (i_ready) begin
                    n_state = wlc_pkg::S_IDLE;
                end
            end
            default: n_state = wlc_pkg::S_IDLE;
        endcase
    end

    // ---------------- state outputs ----------------
    always_comb begin
        o_ready     = 1'b0;
        o_valid     = 1'b0;
        w_ram_we    = 1'b0;
        w_ram_waddr = IW'(i_entry_index);
        w_ram_wdata = '{addr: i_entry_addr, prio: i_entry_priority,
                        weight: i_entry_weight, count: i_entry_count};
        w_ram_raddr = r_idx;
        w_mul_ctrl  = '0;
        unique case (r_state)
            wlc_pkg::S_IDLE: begin
                o_ready     = 1'b1;
                w_ram_we    = w_wr_item && w_wr_in_range;
                w_ram_raddr = '0;
            end
            wlc_pkg::S_EVAL: begin
                // run ahead to the next slot; S_FETCH reads again when this one needs the multiplier
                w_ram_raddr = r_idx + IW'(1);
            end
            wlc_pkg::S_MUL_A: w_mul_ctrl.load_a = 1'b1;
            wlc_pkg::S_MUL_B: w_mul_ctrl.load_b = 1'b1;
            wlc_pkg::S_CMP,
            wlc_pkg::S_FETCH: begin
                w_ram_raddr = r_idx;
            end
            wlc_pkg::S_UPDATE: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_pick_idx;
                w_ram_wdata = '{addr: r_pick.addr, prio: r_pick.prio,
                                weight: r_pick.weight, count: w_cnt_inc};
            end
            wlc_pkg::S_RESP: o_valid = 1'b1;
            default: ;
        endcase
    end

    // ---------------- datapath next values ----------------
    always_comb begin
        n_valid       = r_valid;
        n_idx         = r_idx;
        n_skip        = r_skip;
        n_tier        = r_tier;
        n_picked      = r_picked;
        n_pick_idx    = r_pick_idx;
        n_pick        = r_pick;
        n_cand        = r_cand;
        n_found       = r_found;
        n_chosen_idx  = r_chosen_idx;
        n_chosen_addr = r_chosen_addr;
        unique case (r_state)
            wlc_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_idx         = '0;
                    n_skip        = i_skip_addr;
                    n_tier        = '0;
                    n_picked      = 1'b0;
                    n_found       = 1'b0;
                    n_chosen_idx  = '0;
                    n_chosen_addr = '0;
                    if (w_wr_item && w_wr_in_range) begin
                        n_valid[IW'(i_entry_index)] = i_entry_valid;
                    end
                end
            end
            wlc_pkg::S_EVAL: begin
                if (w_slot_on) begin
                    n_tier = (w_rd.weight != '0 && !r_picked) ? w_rd.prio : w_tier_t;
                end
                if (w_zero || w_first) begin
                    n_picked   = 1'b1;
                    n_pick_idx = r_idx;
                    n_pick     = w_rd;
                end
                if (w_cmp) begin
                    n_cand = w_rd;
                end else if (!w_zero && !w_last) begin
                    n_idx = r_idx + IW'(1);
                end
            end
            wlc_pkg::S_CMP: begin
                if (w_less) begin
                    n_pick_idx = r_idx;
                    n_pick     = r_cand;
                end
                if (!w_last) begin
                    n_idx = r_idx + IW'(1);
                end
            end
            wlc_pkg::S_UPDATE: begin
                n_found       = 1'b1;
                n_chosen_idx  = wlc_pkg::IDX_W'(r_pick_idx);
                n_chosen_addr = r_pick.addr;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= wlc_pkg::S_IDLE;
            r_valid  <= '0;
            r_picked <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_picked <= n_picked;
            r_found  <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx         <= n_idx;
        r_skip        <= n_skip;
        r_tier        <= n_tier;
        r_pick_idx    <= n_pick_idx;
        r_pick        <= n_pick;
        r_cand        <= n_cand;
        r_chosen_idx  <= n_chosen_idx;
        r_chosen_addr <= n_chosen_addr;
    end

    wlc_ram #(
        .WIDTH ($bits(wlc_pkg::t_entry)),
        .DEPTH (MAX_SERVERS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    wlc_mul_unit u_mul (
        .i_clk         (i_clk),
        .i_ctrl        (w_mul_ctrl),
        .i_cand_count  (r_cand.count),
        .i_cand_weight (r_cand.weight),
        .i_pick_count  (r_pick.count),
        .i_pick_weight (r_pick.weight),
        .o_less        (w_less)
    );

    assign o_found        = r_found;
    assign o_chosen_index = r_chosen_idx;
    assign o_chosen_addr  = r_chosen_addr;

endmodule

// ----- src/wlc_ram.sv -----
// ----------------------------------------------------------------------------
// wlc_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module wlc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/wlc_mul_unit.sv -----
// ----------------------------------------------------------------------------
// wlc_mul_unit: shared cross-multiply compare unit
// One 32x16 multiplier used twice per comparison; products are registered
// and compared on the following cycle.
// ----------------------------------------------------------------------------
module wlc_mul_unit (
    input  logic                        i_clk,
    input  wlc_pkg::t_mul_ctrl          i_ctrl,
    input  logic [wlc_pkg::CNT_W-1:0]   i_cand_count,
    input  logic [wlc_pkg::WGT_W-1:0]   i_cand_weight,
    input  logic [wlc_pkg::CNT_W-1:0]   i_pick_count,
    input  logic [wlc_pkg::WGT_W-1:0]   i_pick_weight,
    output logic                        o_less
);

    logic [wlc_pkg::CNT_W-1:0]  w_op_cnt;
    logic [wlc_pkg::WGT_W-1:0]  w_op_wgt;
    logic [wlc_pkg::PROD_W-1:0] w_prod;
    logic [wlc_pkg::PROD_W-1:0] r_prod_a;
    logic [wlc_pkg::PROD_W-1:0] r_prod_b;

    assign w_op_cnt = i_ctrl.load_a ? i_cand_count  : i_pick_count;
    assign w_op_wgt = i_ctrl.load_a ? i_pick_weight : i_cand_weight;
    assign w_prod   = wlc_pkg::PROD_W'(w_op_cnt) * wlc_pkg::PROD_W'(w_op_wgt);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_a) begin
            r_prod_a <= w_prod;
        end
        if (i_ctrl.load_b) begin
            r_prod_b <= w_prod;
        end
    end

    // candidate ratio strictly below the pick's: ties keep the earlier slot
    assign o_less = r_prod_a < r_prod_b;

endmodule

// ----- src/wlc_checker.sv -----
// ----------------------------------------------------------------------------
// wlc_checker: port-level checks for the weighted least-conn picker
// Watches the two channels and the result payload over time.
// ----------------------------------------------------------------------------
module wlc_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic                           o_ready,
    input  logic                           i_operation,
    input  logic [wlc_pkg::IDX_W-1:0]      i_entry_index,
    input  logic                           i_entry_valid,
    input  logic [wlc_pkg::ADDR_W-1:0]     i_entry_addr,
    input  logic [wlc_pkg::PRIO_W-1:0]     i_entry_priority,
    input  logic [wlc_pkg::WGT_W-1:0]      i_entry_weight,
    input  logic [wlc_pkg::CNT_W-1:0]      i_entry_count,
    input  logic [wlc_pkg::ADDR_W-1:0]     i_skip_addr,
    input  logic                           o_valid,
    input  logic                           i_ready,
    input  logic                           o_found,
    input  logic [wlc_pkg::IDX_W-1:0]      o_chosen_index,
    input  logic [wlc_pkg::ADDR_W-1:0]     o_chosen_addr
);

    // a pending result holds until taken
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_found)
            && $stable(o_chosen_index) && $stable(o_chosen_addr))
        else $error("result changed while stalled");

    // one item in flight: no new item while a result waits
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("request taken while a result is pending");

    // an empty result carries zero index and address
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> (o_chosen_index == '0) && (o_chosen_addr == '0))
        else $error("empty result with non-zero fields");

    // a write item answers on the next cycle with nothing found
    a_write_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_operation == wlc_pkg::OP_WRITE) |=> o_valid && !o_found)
        else $error("write item gave a wrong result");

endmodule

bind weighted_least_conn_picker wlc_checker u_wlc_checker (.*);

// ----- verif/weighted_least_conn_picker_tb.sv -----
// ----------------------------------------------------------------------------
// weighted_least_conn_picker_tb: self-checking bench for the server picker
// Drives write and schedule items through the valid/ready request channel,
// predicts every pick with a model of the slot table held in the bench, and
// checks each result. Both sides idle at random; a long result stall and
// full drains are forced along the way.
// ----------------------------------------------------------------------------
module weighted_least_conn_picker_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          SLOTS           = 16;
    localparam int unsigned WATCHDOG_CYCLES = 2000;
    localparam int unsigned HOLD_CYCLES     = 300;
    localparam int unsigned RANDOM_ITEMS    = 1000;
    localparam int          POOL_SIZE       = 6;

    typedef struct packed {
        logic                       op;
        logic [wlc_pkg::IDX_W-1:0]  index;
        logic                       valid;
        logic [wlc_pkg::ADDR_W-1:0] addr;
        logic [wlc_pkg::PRIO_W-1:0] prio;
        logic [wlc_pkg::WGT_W-1:0]  weight;
        logic [wlc_pkg::CNT_W-1:0]  count;
        logic [wlc_pkg::ADDR_W-1:0] skip;
    } t_req;

    typedef struct packed {
        logic                       found;
        logic [wlc_pkg::IDX_W-1:0]  index;
        logic [wlc_pkg::ADDR_W-1:0] addr;
    } t_pick;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_ready;
    logic                       i_operation;
    logic [wlc_pkg::IDX_W-1:0]  i_entry_index;
    logic                       i_entry_valid;
    logic [wlc_pkg::ADDR_W-1:0] i_entry_addr;
    logic [wlc_pkg::PRIO_W-1:0] i_entry_priority;
    logic [wlc_pkg::WGT_W-1:0]  i_entry_weight;
    logic [wlc_pkg::CNT_W-1:0]  i_entry_count;
    logic [wlc_pkg::ADDR_W-1:0] i_skip_addr;
    logic                       o_valid;
    logic                       i_ready;
    logic                       o_found;
    logic [wlc_pkg::IDX_W-1:0]  o_chosen_index;
    logic [wlc_pkg::ADDR_W-1:0] o_chosen_addr;

    // bench copy of the server table
    logic                       slot_on  [SLOTS];
    wlc_pkg::t_entry            slot_tab [SLOTS];

    t_pick                      pick_q[$];
    logic [wlc_pkg::ADDR_W-1:0] addr_pool [POOL_SIZE];

    int unsigned n_errors     = 0;
    int unsigned n_writes     = 0;
    int unsigned n_schedules  = 0;
    int unsigned n_picks      = 0;
    int unsigned n_saturated  = 0;
    int unsigned n_results    = 0;
    int unsigned quiet_cycles = 0;
    int unsigned rx_hold_len  = 0;
    bit          tx_idle_on   = 1'b0;
    bit          rx_idle_on   = 1'b0;

    weighted_least_conn_picker #(
        .MAX_SERVERS (SLOTS)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_operation      (i_operation),
        .i_entry_index    (i_entry_index),
        .i_entry_valid    (i_entry_valid),
        .i_entry_addr     (i_entry_addr),
        .i_entry_priority (i_entry_priority),
        .i_entry_weight   (i_entry_weight),
        .i_entry_count    (i_entry_count),
        .i_skip_addr      (i_skip_addr),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_found          (o_found),
        .o_chosen_index   (o_chosen_index),
        .o_chosen_addr    (o_chosen_addr)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic t_pick predict_pick(input t_req r);
        t_pick                      res;
        logic [wlc_pkg::PRIO_W-1:0] tier;
        logic                       have;
        int                         sel;
        logic [wlc_pkg::CNT_W-1:0]  sel_cnt;
        logic [63:0]                lhs;
        logic [63:0]                rhs;
        res = '0;
        if (r.op == wlc_pkg::OP_WRITE) begin
            n_writes++;
            slot_on[r.index]         = r.valid;
            slot_tab[r.index].addr   = r.addr;
            slot_tab[r.index].prio   = r.prio;
            slot_tab[r.index].weight = r.weight;
            slot_tab[r.index].count  = r.count;
            return res;
        end
        n_schedules++;
        tier    = '0;
        have    = 1'b0;
        sel     = 0;
        sel_cnt = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (!slot_on[i] || slot_tab[i].addr == r.skip) continue;
            if (tier == '0) tier = slot_tab[i].prio;
            if (slot_tab[i].weight == '0) continue;
            if (!have && slot_tab[i].prio != tier) tier = slot_tab[i].prio;
            if (slot_tab[i].prio != tier) continue;
            // idle server wins outright
            if (slot_tab[i].count == '0) begin
                have = 1'b1;
                sel  = i;
                break;
            end
            if (!have) begin
                have    = 1'b1;
                sel     = i;
                sel_cnt = slot_tab[i].count;
            end else begin
                // 64-bit context, so the cross products cannot wrap
                lhs = 64'(slot_tab[i].count) * 64'(slot_tab[sel].weight);
                rhs = 64'(sel_cnt) * 64'(slot_tab[i].weight);
                if (lhs < rhs) begin
                    sel     = i;
                    sel_cnt = slot_tab[i].count;
                end
            end
        end
        if (have) begin
            n_picks++;
            if (slot_tab[sel].count == '1)
                n_saturated++;
            else
                slot_tab[sel].count = slot_tab[sel].count + 1'b1;
            res.found = 1'b1;
            res.index = sel[wlc_pkg::IDX_W-1:0];
            res.addr  = slot_tab[sel].addr;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // checking: predicts on each accepted item, compares each result
    // ------------------------------------------------------------------
    task automatic report_miss(input string what, input logic [31:0] want, got);
        n_errors++;
        if (n_errors <= 10)
            $display("%0t: result %0d %0s mismatch: expected %h, got %h",
                     $realtime, n_results, what, want, got);
    endtask

    always @(posedge i_clk) begin : result_check
        t_req  r;
        t_pick want;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                r.op     = i_operation;
                r.index  = i_entry_index;
                r.valid  = i_entry_valid;
                r.addr   = i_entry_addr;
                r.prio   = i_entry_priority;
                r.weight = i_entry_weight;
                r.count  = i_entry_count;
                r.skip   = i_skip_addr;
                pick_q.push_back(predict_pick(r));
            end
            if (o_valid && i_ready) begin
                n_results++;
                if (pick_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("%0t: result with nothing outstanding (found %b idx %0d addr %h)",
                                 $realtime, o_found, o_chosen_index, o_chosen_addr);
                end else begin
                    want = pick_q.pop_front();
                    if (o_found !== want.found)
                        report_miss("found", 32'(want.found), 32'(o_found));
                    if (o_chosen_index !== want.index)
                        report_miss("chosen_index", 32'(want.index), 32'(o_chosen_index));
                    if (o_chosen_addr !== want.addr)
                        report_miss("chosen_addr", want.addr, o_chosen_addr);
                end
            end
            if ((i_valid && o_ready) || (o_valid && i_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    initial begin : watchdog
        do @(negedge i_clk); while (quiet_cycles < WATCHDOG_CYCLES);
        $display("timeout: no handshake for %0d cycles, %0d results outstanding",
                 WATCHDOG_CYCLES, pick_q.size());
        $display("weighted_least_conn_picker_tb: errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // idling
    // ------------------------------------------------------------------
    function automatic int unsigned idle_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 80) return $urandom_range(1, 3);
        if (roll < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result side: random stalls, plus a long hold-off on request
    initial begin : result_sink
        int unsigned n;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_len != 0) begin
                n           = rx_hold_len;
                rx_hold_len = 0;
                i_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat (idle_len()) @(posedge i_clk);
            end
            i_ready <= 1'b1;
        end
    end

    // flags change between edges so neither side races on them; the request
    // line is dropped so a taken item is not left on offer meanwhile
    task automatic set_idling(input bit tx_on, input bit rx_on);
        i_valid <= 1'b0;
        @(negedge i_clk);
        tx_idle_on = tx_on;
        rx_idle_on = rx_on;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------
    task automatic send_item(input t_req r);
        int unsigned gap;
        i_valid          <= 1'b1;
        i_operation      <= r.op;
        i_entry_index    <= r.index;
        i_entry_valid    <= r.valid;
        i_entry_addr     <= r.addr;
        i_entry_priority <= r.prio;
        i_entry_weight   <= r.weight;
        i_entry_count    <= r.count;
        i_skip_addr      <= r.skip;
        do @(posedge i_clk); while (!o_ready);
        gap = (tx_idle_on && $urandom_range(0, 1) == 0) ? idle_len() : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_slot(input logic [wlc_pkg::IDX_W-1:0] idx, input logic on,
                              input logic [wlc_pkg::ADDR_W-1:0] addr,
                              input logic [wlc_pkg::PRIO_W-1:0] prio,
                              input logic [wlc_pkg::WGT_W-1:0] weight,
                              input logic [wlc_pkg::CNT_W-1:0] count);
        t_req r;
        r.op     = wlc_pkg::OP_WRITE;
        r.index  = idx;
        r.valid  = on;
        r.addr   = addr;
        r.prio   = prio;
        r.weight = weight;
        r.count  = count;
        r.skip   = $urandom;
        send_item(r);
    endtask

    task automatic schedule(input logic [wlc_pkg::ADDR_W-1:0] skip);
        t_req r;
        r.op     = wlc_pkg::OP_SCHEDULE;
        r.index  = wlc_pkg::IDX_W'($urandom_range(0, SLOTS - 1));
        r.valid  = 1'($urandom_range(0, 1));
        r.addr   = $urandom;
        r.prio   = wlc_pkg::PRIO_W'($urandom_range(0, 16'hFFFF));
        r.weight = wlc_pkg::WGT_W'($urandom_range(0, 16'hFFFF));
        r.count  = $urandom;
        r.skip   = skip;
        send_item(r);
    endtask

    // sender stops until every result is back
    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pick_q.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // random content
    // ------------------------------------------------------------------
    function automatic logic [wlc_pkg::ADDR_W-1:0] rand_addr();
        if ($urandom_range(0, 99) < 85) return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    function automatic t_req rand_item();
        t_req        r;
        int unsigned roll;
        r.op    = ($urandom_range(0, 9) < 6) ? wlc_pkg::OP_SCHEDULE : wlc_pkg::OP_WRITE;
        r.index = wlc_pkg::IDX_W'($urandom_range(0, SLOTS - 1));
        r.valid = ($urandom_range(0, 6) != 0);
        r.addr  = rand_addr();
        roll = $urandom_range(0, 99);
        if (roll < 70)      r.prio = wlc_pkg::PRIO_W'($urandom_range(1, 3));
        else if (roll < 85) r.prio = '0;
        else                r.prio = wlc_pkg::PRIO_W'($urandom_range(0, 16'hFFFF));
        roll = $urandom_range(0, 99);
        if (roll < 10)      r.weight = '0;
        else if (roll < 70) r.weight = wlc_pkg::WGT_W'($urandom_range(1, 8));
        else                r.weight = wlc_pkg::WGT_W'($urandom_range(0, 16'hFFFF));
        roll = $urandom_range(0, 99);
        if (roll < 15)      r.count = '0;
        else if (roll < 60) r.count = wlc_pkg::CNT_W'($urandom_range(1, 50));
        else if (roll < 85) r.count = $urandom;
        else                r.count = 32'hFFFF_FFFF - $urandom_range(0, 3);
        r.skip = ($urandom_range(0, 1) == 0) ? addr_pool[$urandom_range(0, POOL_SIZE - 1)]
                                             : $urandom;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_empty_table();
        schedule('0);
        schedule('1);
        wait_for_results();
    endtask

    task automatic test_count_saturation();
        write_slot(4'd15, 1'b1, '1, '1, '1, 32'hFFFF_FFFE);
        schedule('0);
        schedule('0);
        // only server skipped: nothing to pick
        schedule('1);
        wait_for_results();
    endtask

    task automatic test_tier_and_ratio();
        // zero tier with a busier server in a higher tier behind it
        write_slot(4'd0, 1'b1, '0, '0, 16'd1, 32'd5);
        schedule(32'h1234_5678);
        write_slot(4'd15, 1'b0, '1, '1, '1, '1);
        write_slot(4'd0, 1'b0, $urandom, wlc_pkg::PRIO_W'($urandom),
                   wlc_pkg::WGT_W'($urandom), $urandom);
        // quiesced first server fixes the tier, the next one moves it
        write_slot(4'd1, 1'b1, 32'h0A00_0001, 16'd2, 16'd0, 32'd0);
        write_slot(4'd2, 1'b1, 32'h0A00_0002, 16'd3, 16'd4, 32'd8);
        write_slot(4'd3, 1'b1, 32'h0A00_0003, 16'd3, 16'd2, 32'd4);
        schedule('0);   // equal ratios, earlier slot kept
        schedule('0);
        write_slot(4'd4, 1'b1, 32'h0A00_0004, 16'd3, 16'd1, 32'd0);
        write_slot(4'd5, 1'b1, 32'h0A00_0005, 16'd3, 16'd1, 32'd0);
        schedule('0);   // idle server stops the walk
        wait_for_results();
    endtask

    task automatic test_skip_addr();
        schedule(32'h0A00_0004);
        write_slot(4'd6, 1'b1, 32'h0A00_0005, 16'd1, 16'd3, 32'd1);
        schedule(32'h0A00_0005);   // drops both servers sharing the address
        wait_for_results();
    endtask

    task automatic test_result_backpressure();
        set_idling(1'b0, 1'b0);
        @(negedge i_clk);
        rx_hold_len = HOLD_CYCLES;
        @(posedge i_clk);
        repeat (12) send_item(rand_item());
        wait_for_results();
    endtask

    task automatic test_random_traffic(input int unsigned total);
        int unsigned sent;
        int unsigned chunk;
        sent  = 0;
        chunk = 0;
        for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = $urandom;
        while (sent < total) begin
            if (chunk == 0)
                set_idling(1'b0, 1'b0);
            else
                set_idling($urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
            for (int k = 0; k < 50 && sent < total; k++) begin
                send_item(rand_item());
                sent++;
            end
            if (chunk % 4 == 3) wait_for_results();
            chunk++;
        end
        wait_for_results();
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_operation      <= wlc_pkg::OP_WRITE;
        i_entry_index    <= '0;
        i_entry_valid    <= 1'b0;
        i_entry_addr     <= '0;
        i_entry_priority <= '0;
        i_entry_weight   <= '0;
        i_entry_count    <= '0;
        i_skip_addr      <= '0;
        for (int i = 0; i < SLOTS; i++) begin
            slot_on[i]  = 1'b0;
            slot_tab[i] = '0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idling(1'b1, 1'b1);
        test_empty_table();
        test_count_saturation();
        test_tier_and_ratio();
        test_skip_addr();
        test_result_backpressure();
        test_random_traffic(RANDOM_ITEMS);

        repeat (100) @(posedge i_clk);
        n_errors += pick_q.size();
        $display("covered %0d slot writes and %0d schedule requests: %0d picks, %0d at full count",
                 n_writes, n_schedules, n_picks, n_saturated);
        $display("%0d results checked, %0d failures", n_results, n_errors);
        if (n_errors == 0)
            $display("weighted_least_conn_picker_tb: clean");
        else
            $display("weighted_least_conn_picker_tb: errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/wlc_pkg.sv
src/wlc_ram.sv
src/wlc_mul_unit.sv
src/weighted_least_conn_picker.sv
src/wlc_checker.sv
verif/weighted_least_conn_picker_tb.sv
